// File: design/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and helpers for the row finite difference block.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_ROW_LENGTH  = 2'd1;
  localparam logic [1:0] REG_INV_SPACING = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_CEN  = 2'd2;
  localparam logic [1:0] MODE_FIVE = 2'd3;

  localparam int unsigned ROW_MIN     = 6;
  localparam int unsigned NUM_W       = 37;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ceil(2^35 / 3), exact quotient by 3 for values below 2^33
  localparam logic [33:0] RECIP3 = 34'h2_AAAA_AAAB;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_2,
    DIV_12
  } rfd_div_e;

  // order of results caused by one sample (d: stencil slope, e: 0.75*d, e2: 0.75*e)
  typedef enum logic [2:0] {
    K_PASS,
    K_D,
    K_D_E,
    K_E_D,
    K_E2_E_D,
    K_D_E_E2
  } rfd_kind_e;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    rfd_div_e                div;
    rfd_kind_e               kind;
    logic [31:0]             sample;
    logic                    row_end;
  } rfd_entry_t;

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] e2;
    rfd_kind_e   kind;
    logic        row_end;
  } rfd_res_t;

  // 3*d/4, rounded to nearest, ties away from zero
  function automatic logic [31:0] three_quarters(input logic [31:0] d);
    logic [33:0] p;
    logic [33:0] mag;
    logic [33:0] q;
    p   = {{2{d[31]}}, d} + {d[31], d, 1'b0};
    mag = p[33] ? (~p + 34'd1) : p;
    q   = (mag + 34'd2) >> 2;
    return p[33] ? (~q[31:0] + 32'd1) : q[31:0];
  endfunction

endpackage

// File: design/row_finite_difference.sv
// ----------------------------------------------------------------------------
// row_finite_difference
// Streaming first derivative along grid rows, Q16.16 in and out.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while in_stall_o is low; a sample with two
//   or three slopes holds the output longer, absorbed by a 4-entry queue
// reset: mode central, row length 64, spacing 1.0, window and column cleared;
//   no clearing pass, samples are taken right after reset
module row_finite_difference import rfd_pkg::*; #(
  parameter int unsigned MAX_ROW = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] slope_o,
  output logic        row_end_o,
  output logic        run_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [1:0]  mode_q;
  logic [12:0] row_length_q;
  logic [31:0] inv_spacing_q;

  logic       accept;
  logic       push, pop, empty, full;
  rfd_entry_t entry, head;
  logic       res_valid, load_ok;
  rfd_res_t   res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_CEN;
      row_length_q  <= 13'd64;
      inv_spacing_q <= 32'h0001_0000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:        mode_q        <= cfg_data_i[1:0];
        REG_ROW_LENGTH:  row_length_q  <= cfg_data_i[12:0];
        REG_INV_SPACING: inv_spacing_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rfd_front #(
    .MAX_ROW(MAX_ROW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (sample_i),
    .mode_i      (mode_q),
    .row_length_i(row_length_q),
    .push_o      (push),
    .entry_o     (entry)
  );

  rfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .full_o (full)
  );

  rfd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .inv_spacing_i(inv_spacing_q),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .load_ok_i    (load_ok),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rfd_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .load_ok_o  (load_ok),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .slope_o    (slope_o),
    .row_end_o  (row_end_o),
    .run_last_o (run_last_o)
  );

endmodule

// File: design/rfd_front.sv
// ----------------------------------------------------------------------------
// rfd_front
// Takes samples, keeps the sample window and row column, forms the
// difference numerator and decides which results the sample causes.
// ----------------------------------------------------------------------------
module rfd_front import rfd_pkg::*; #(
  parameter int unsigned MAX_ROW = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [31:0] sample_i,
  input  logic [1:0]  mode_i,
  input  logic [12:0] row_length_i,
  output logic        push_o,
  output rfd_entry_t  entry_o
);

  localparam int unsigned CW = $clog2(MAX_ROW);
  localparam int unsigned LW = ($clog2(MAX_ROW + 1) > 13) ? $clog2(MAX_ROW + 1) : 13;

  logic [31:0]   w0_q, w1_q, w2_q, w3_q;
  logic [CW-1:0] col_q, col_d;
  logic [LW-1:0] rl, len, colx;
  logic          last;
  logic          emits;
  logic signed [NUM_W-1:0] s, a0, a1, a2, a3;

  always_comb begin
    rl = LW'(row_length_i);
    if (rl < LW'(ROW_MIN)) begin
      len = LW'(ROW_MIN);
    end else if (rl > LW'(MAX_ROW)) begin
      len = LW'(MAX_ROW);
    end else begin
      len = rl;
    end
    colx  = LW'(col_q);
    last  = colx >= (len - LW'(1));
    col_d = last ? '0 : col_q + CW'(1);
  end

  always_comb begin
    s  = NUM_W'(signed'(sample_i));
    a0 = NUM_W'(signed'(w0_q));
    a1 = NUM_W'(signed'(w1_q));
    a2 = NUM_W'(signed'(w2_q));
    a3 = NUM_W'(signed'(w3_q));

    entry_o.sample  = sample_i;
    entry_o.row_end = last;
    entry_o.num     = '0;
    entry_o.div     = DIV_1;
    entry_o.kind    = K_PASS;
    emits           = 1'b1;
    case (mode_i)
      MODE_FWD: begin
        emits        = colx >= LW'(1);
        entry_o.num  = s - a0;
        entry_o.div  = DIV_1;
        entry_o.kind = last ? K_D_E : K_D;
      end
      MODE_CEN: begin
        emits        = colx >= LW'(2);
        entry_o.num  = s - a1;
        entry_o.div  = DIV_2;
        if (colx == LW'(2)) begin
          entry_o.kind = K_E_D;
        end else begin
          entry_o.kind = last ? K_D_E : K_D;
        end
      end
      MODE_FIVE: begin
        emits        = colx >= LW'(4);
        entry_o.num  = ((a0 - a2) <<< 3) - (s - a3);
        entry_o.div  = DIV_12;
        if (colx == LW'(4)) begin
          entry_o.kind = K_E2_E_D;
        end else begin
          entry_o.kind = last ? K_D_E_E2 : K_D;
        end
      end
      default: begin
        entry_o.kind = K_PASS;
      end
    endcase
    push_o = accept_i && emits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q  <= '0;
      w1_q  <= '0;
      w2_q  <= '0;
      w3_q  <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      w0_q  <= sample_i;
      w1_q  <= w0_q;
      w2_q  <= w1_q;
      w3_q  <= w2_q;
      col_q <= col_d;
    end
  end

endmodule

// File: design/rfd_queue.sv
// ----------------------------------------------------------------------------
// rfd_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module rfd_queue import rfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rfd_entry_t entry_i,
  input  logic       pop_i,
  output rfd_entry_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  rfd_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    empty_o = count_q == '0;
    full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
    head_o  = mem_q[rd_q];
    count_d = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + QCNT_W'(1))
    else $error("queue count lost a push");

endmodule

// File: design/rfd_scale.sv
// ----------------------------------------------------------------------------
// rfd_scale
// Back part pipeline: multiplies the numerator by the reciprocal spacing,
// divides by 1, 2 or 12 with rounding, saturates and forms the edge values.
// ----------------------------------------------------------------------------
module rfd_scale import rfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] inv_spacing_i,
  input  rfd_entry_t  head_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic        load_ok_i,
  output logic        res_valid_o,
  output rfd_res_t    res_o
);

  typedef struct packed {
    logic        neg;
    rfd_div_e    div;
    rfd_kind_e   kind;
    logic [31:0] sample;
    logic        row_end;
  } meta_t;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  meta_t m1_q, m2_q, m3_q, m4_q;

  // stage 1
  logic [NUM_W-1:0] mag37;
  logic [35:0]      mag;
  logic [49:0]      ph1_q, pl1_q;

  // stage 2
  logic [68:0] y;
  logic [50:0] x12;
  logic [32:0] x2_d, x2_q;
  logic        direct2_d, direct2_q;

  // stage 3
  logic [49:0] ph3_q;
  logic [50:0] pl3_q;
  logic [32:0] x3_q;
  logic        direct3_q;

  // stage 4
  logic [67:0] prod;
  logic [32:0] t;
  logic [31:0] d4_d, d4_q;

  // stage 5 and 6
  logic [31:0] d5_q, e5_q;
  rfd_kind_e   k5_q;
  logic        re5_q;
  rfd_res_t    res_q;

  always_comb begin
    en    = !v6_q || load_ok_i;
    pop_o = en && !empty_i;
  end

  always_comb begin
    mag37 = head_i.num[NUM_W-1] ? (~head_i.num + NUM_W'(1)) : head_i.num;
    mag   = mag37[35:0];
  end

  always_comb begin
    y = {1'b0, ph1_q, 18'b0} + 69'(pl1_q);
    direct2_d = 1'b1;
    x2_d      = '0;
    x12       = '0;
    case (m1_q.div)
      DIV_1: begin
        y = y + 69'(1 << 15);
        x2_d = (|y[68:47]) ? 33'h0_8000_0000 : 33'(y[46:16]);
      end
      DIV_2: begin
        y = y + 69'(1 << 16);
        x2_d = (|y[68:48]) ? 33'h0_8000_0000 : 33'(y[47:17]);
      end
      DIV_12: begin
        y = y + 69'(3 << 17);
        direct2_d = 1'b0;
        x12  = y[68:18];
        // beyond 3*2^31 the quotient saturates anyway
        x2_d = (x12 >= 51'h1_8000_0000) ? 33'h1_8000_0000 : x12[32:0];
      end
      default: begin
        x2_d = '0;
      end
    endcase
  end

  always_comb begin
    prod = {1'b0, ph3_q, 17'b0} + 68'(pl3_q);
    t    = direct3_q ? x3_q : prod[67:35];
    if (m3_q.kind == K_PASS) begin
      d4_d = m3_q.sample;
    end else if (m3_q.neg) begin
      d4_d = (t[32] | t[31]) ? 32'h8000_0000 : (~t[31:0] + 32'd1);
    end else begin
      d4_d = (t[32] | t[31]) ? 32'h7FFF_FFFF : t[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q.neg     <= head_i.num[NUM_W-1];
      m1_q.div     <= head_i.div;
      m1_q.kind    <= head_i.kind;
      m1_q.sample  <= head_i.sample;
      m1_q.row_end <= head_i.row_end;
      ph1_q        <= {32'b0, mag[35:18]} * {18'b0, inv_spacing_i};
      pl1_q        <= {32'b0, mag[17:0]} * {18'b0, inv_spacing_i};

      m2_q      <= m1_q;
      x2_q      <= x2_d;
      direct2_q <= direct2_d;

      m3_q      <= m2_q;
      x3_q      <= x2_q;
      direct3_q <= direct2_q;
      ph3_q     <= {34'b0, x2_q[32:17]} * {16'b0, RECIP3};
      pl3_q     <= {34'b0, x2_q[16:0]} * {17'b0, RECIP3};

      m4_q <= m3_q;
      d4_q <= d4_d;

      d5_q  <= d4_q;
      e5_q  <= three_quarters(d4_q);
      k5_q  <= m4_q.kind;
      re5_q <= m4_q.row_end;

      res_q.d       <= d5_q;
      res_q.e       <= e5_q;
      res_q.e2      <= three_quarters(e5_q);
      res_q.kind    <= k5_q;
      res_q.row_end <= re5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign res_valid_o = v6_q;
  assign res_o       = res_q;

endmodule

// File: design/rfd_emit.sv
// ----------------------------------------------------------------------------
// rfd_emit
// Output register: holds the values of one sample and sends its results
// one per cycle in row order, unless out_stall_i holds the output.
// ----------------------------------------------------------------------------
module rfd_emit import rfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  rfd_res_t    res_i,
  output logic        load_ok_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] slope_o,
  output logic        row_end_o,
  output logic        run_last_o
);

  rfd_res_t   cur_q;
  logic       busy_q;
  logic [1:0] step_q;
  logic [1:0] n_last;
  logic       last_step;
  logic       take;

  always_comb begin
    slope_o   = cur_q.d;
    row_end_o = 1'b0;
    n_last    = 2'd0;
    case (cur_q.kind)
      K_PASS: begin
        row_end_o = cur_q.row_end;
      end
      K_D: begin
        n_last = 2'd0;
      end
      K_D_E: begin
        n_last    = 2'd1;
        slope_o   = (step_q == 2'd0) ? cur_q.d : cur_q.e;
        row_end_o = step_q == 2'd1;
      end
      K_E_D: begin
        n_last  = 2'd1;
        slope_o = (step_q == 2'd0) ? cur_q.e : cur_q.d;
      end
      K_E2_E_D: begin
        n_last  = 2'd2;
        slope_o = (step_q == 2'd0) ? cur_q.e2 : ((step_q == 2'd1) ? cur_q.e : cur_q.d);
      end
      K_D_E_E2: begin
        n_last    = 2'd2;
        slope_o   = (step_q == 2'd0) ? cur_q.d : ((step_q == 2'd1) ? cur_q.e : cur_q.e2);
        row_end_o = step_q == 2'd2;
      end
      default: begin
        n_last = 2'd0;
      end
    endcase
    last_step   = step_q == n_last;
    run_last_o  = last_step;
    out_valid_o = busy_q;
    take        = busy_q && !out_stall_i;
    load_ok_o   = !busy_q || (take && last_step);
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && res_valid_i) begin
      cur_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (load_ok_o) begin
      busy_q <= res_valid_i;
      step_q <= '0;
    end else if (take) begin
      step_q <= step_q + 2'd1;
    end
  end

endmodule

// File: tb/sv/row_finite_difference_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_finite_difference_test
// Drives sample rows through the finite difference block under every rule,
// row lengths from the clamped minimum to the full row, and spacing extremes.
// A local predictor works out the slopes of each accepted sample. A checker
// compares every slope, row end and run end flag in order, while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module row_finite_difference_test import rfd_pkg::*;;

  localparam int unsigned ROW_CAP     = 4096;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE_CYC  = 12;

  typedef struct {
    logic [31:0] slope;
    logic        row_end;
    logic        run_last;
  } slope_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] slope_o;
  logic        row_end_o;
  logic        run_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  // predictor state, mirrors the block after reset
  logic [1:0]  cur_mode = MODE_CEN;
  logic [12:0] cur_row  = 13'd64;
  logic [31:0] cur_inv  = 32'h0001_0000;
  longint      win[5]   = '{default: 0};
  int unsigned col      = 0;

  slope_t slopes_due[$];

  int mismatches     = 0;
  int slopes_checked = 0;
  int samples_sent   = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;
  int stall_pct      = 0;
  int stall_left     = 0;
  int long_hold      = 0;

  row_finite_difference #(
    .MAX_ROW(ROW_CAP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .slope_o    (slope_o),
    .row_end_o  (row_end_o),
    .run_last_o (run_last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slopes outstanding", cycle_count,
               slopes_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold when a test asks for one
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      stall_left = long_hold;
      long_hold  = 0;
    end else if (stall_left == 0 && $urandom_range(99) < stall_pct) begin
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 3);
    end
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // round(num * inv / (div * 2^16)), ties away from zero, saturated
  function automatic logic [31:0] scaled_diff(longint num, logic [31:0] inv,
                                              int unsigned div);
    logic [63:0] mag;
    logic [79:0] prod;
    logic [79:0] den;
    logic [79:0] t;
    logic [79:0] rem;
    mag  = (num < 0) ? -num : num;
    prod = 80'(mag) * 80'(inv);
    den  = 80'(div) << 16;
    t    = prod / den;
    rem  = prod % den;
    if ((rem << 1) >= den) t = t + 80'd1;
    if (num < 0) return (t >= 80'h8000_0000) ? 32'h8000_0000 : ~t[31:0] + 32'd1;
    return (t > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : t[31:0];
  endfunction

  // 0.75 * d for the edge slopes
  function automatic logic [31:0] taper(logic [31:0] d);
    longint p;
    longint q;
    p = 3 * longint'($signed(d));
    q = ((p < 0) ? -p : p) + 2;
    q = q >> 2;
    return (p < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic void predict_slopes(logic [31:0] s);
    int unsigned len;
    logic        at_end;
    logic [31:0] d;
    logic [31:0] e;
    slope_t      batch[$];
    len = (cur_row < ROW_MIN) ? ROW_MIN : ((cur_row > ROW_CAP) ? ROW_CAP : cur_row);
    at_end = (col >= len - 1);
    for (int i = 4; i > 0; i--) win[i] = win[i-1];
    win[0] = longint'($signed(s));
    case (cur_mode)
      MODE_FWD: begin
        if (col >= 1) begin
          d = scaled_diff(win[0] - win[1], cur_inv, 1);
          batch.push_back(slope_t'{d, 1'b0, 1'b0});
          if (at_end) batch.push_back(slope_t'{taper(d), 1'b1, 1'b0});
        end
      end
      MODE_CEN: begin
        if (col >= 2) begin
          d = scaled_diff(win[0] - win[2], cur_inv, 2);
          if (col == 2) batch.push_back(slope_t'{taper(d), 1'b0, 1'b0});
          batch.push_back(slope_t'{d, 1'b0, 1'b0});
          if (at_end) batch.push_back(slope_t'{taper(d), 1'b1, 1'b0});
        end
      end
      MODE_FIVE: begin
        if (col >= 4) begin
          d = scaled_diff(8 * (win[1] - win[3]) - (win[0] - win[4]), cur_inv, 12);
          e = taper(d);
          if (col == 4) begin
            batch.push_back(slope_t'{taper(e), 1'b0, 1'b0});
            batch.push_back(slope_t'{e, 1'b0, 1'b0});
          end
          batch.push_back(slope_t'{d, 1'b0, 1'b0});
          if (at_end) begin
            batch.push_back(slope_t'{e, 1'b0, 1'b0});
            batch.push_back(slope_t'{taper(e), 1'b1, 1'b0});
          end
        end
      end
      default: batch.push_back(slope_t'{s, at_end, 1'b0});
    endcase
    if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
    foreach (batch[k]) slopes_due.push_back(batch[k]);
    col = at_end ? 0 : col + 1;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at slope %0d: expected %h, got %h", field,
               slopes_checked, want, got);
  endtask

  always @(posedge clk_i) begin
    slope_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (slopes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected slope %h with none pending", slope_o);
      end else begin
        want = slopes_due.pop_front();
        if (slope_o !== want.slope) flag_mismatch("slope", want.slope, slope_o);
        if (row_end_o !== want.row_end) flag_mismatch("row_end", want.row_end, row_end_o);
        if (run_last_o !== want.run_last)
          flag_mismatch("run_last", want.run_last, run_last_o);
      end
      slopes_checked++;
    end
  end

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      sample_i   <= $urandom;
    end
  endtask

  // one sample item, after an optional gap; returns at the accepting edge
  task automatic send_sample(logic [31:0] s, int gap);
    if (gap > 0) idle_input(gap);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    predict_slopes(s);
    samples_sent++;
  endtask

  task automatic settle();
    idle_input(1);
    while (slopes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:        cur_mode = val[1:0];
      REG_ROW_LENGTH:  cur_row  = val[12:0];
      REG_INV_SPACING: cur_inv  = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] m, logic [31:0] rl, logic [31:0] inv);
    settle();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_ROW_LENGTH, rl);
    write_reg(REG_INV_SPACING, inv);
  endtask

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    return ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2:    return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  // reset settings: central rule, row of 64, spacing 1.0
  task automatic test_reset_state();
    logic [31:0] vals[] = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
    stall_pct = 25;
    foreach (vals[i]) send_sample(vals[i], pick_gap(30));
  endtask

  // row length below the minimum acts as 6 and ends the current row early
  task automatic test_row_clamp_low();
    settle();
    write_reg(REG_ROW_LENGTH, 32'd0);
    for (int k = 0; k < 7; k++) send_sample(32'(k * 3) << 16, pick_gap(30));
  endtask

  // forward rule switched at a row start, full-scale spacing saturates both ways
  task automatic test_forward_extremes();
    logic [31:0] vals[] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                            32'hFFFF_0000};
    settle();
    write_reg(REG_MODE, {30'd0, MODE_FWD});
    write_reg(REG_INV_SPACING, 32'hFFFF_FFFF);
    foreach (vals[i]) send_sample(vals[i], pick_gap(30));
  endtask

  task automatic test_five_point();
    logic [31:0] vals[] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h0000_0001};
    settle();
    write_reg(REG_MODE, {30'd0, MODE_FIVE});
    write_reg(REG_INV_SPACING, 32'h0001_8000);
    foreach (vals[i]) send_sample(vals[i], pick_gap(30));
  endtask

  // samples come back unchanged, spacing of zero has no effect
  task automatic test_pass_through();
    logic [31:0] vals[] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                            32'h0, 32'hFFFF_FFFF};
    settle();
    write_reg(REG_MODE, {30'd0, MODE_PASS});
    write_reg(REG_INV_SPACING, 32'h0);
    foreach (vals[i]) send_sample(vals[i], pick_gap(30));
  endtask

  // row length above the cap is held to the full row, streamed back to back
  task automatic test_long_row();
    stall_pct = 0;
    set_config(MODE_FWD, 32'd8191, 32'h0002_0000);
    repeat (48) send_sample(rand_sample(), 0);
  endtask

  task automatic test_backpressure();
    set_config(MODE_FIVE, 32'd6, 32'h0001_0000);
    // output held off while the sender keeps going, so the input stalls
    long_hold = 80;
    repeat (40) send_sample(rand_sample(), 0);
    // sender waits for every pending slope before going on
    idle_input(1);
    while (slopes_due.size() != 0) @(posedge clk_i);
    stall_pct = 30;
    repeat (12) send_sample(rand_sample(), 0);
  endtask

  task automatic test_random_rows();
    logic [31:0] rl;
    logic [31:0] inv;
    int          gap_pct;
    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(9))
        0:       rl = $urandom_range(0, 5);
        1:       rl = ROW_CAP;
        2:       rl = $urandom_range(ROW_CAP + 1, 8191);
        default: rl = $urandom_range(6, 12);
      endcase
      case ($urandom_range(7))
        0:       inv = 32'h0;
        1:       inv = 32'hFFFF_FFFF;
        2:       inv = $urandom;
        default: inv = $urandom_range(32'h0000_4000, 32'h0004_0000);
      endcase
      set_config(2'($urandom_range(3)), rl, inv);
      stall_pct = (ph == 0) ? 0 : $urandom_range(5, 40);
      gap_pct   = (ph == 1) ? 0 : $urandom_range(10, 50);
      repeat (36) send_sample(rand_sample(), pick_gap(gap_pct));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_row_clamp_low();
    test_forward_extremes();
    test_five_point();
    test_pass_through();
    test_long_row();
    test_backpressure();
    test_random_rows();
    settle();
    $display("sent %0d samples, checked %0d slopes, %0d register writes", samples_sent,
             slopes_checked, reg_writes);
    $display("rules pass/forward/central/five-point, rows clamped low to full, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
